/* rtl/nd_pad_address_generator_macros.svh */
// Assertion macros shared by the pad address generator RTL.
// Expects signals clk and rst_n in the scope where a macro is used.
`ifndef ND_PAD_ADDRESS_GENERATOR_MACROS_SVH
`define ND_PAD_ADDRESS_GENERATOR_MACROS_SVH

// Condition holds on every clock edge out of reset
`define NDPAD_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("ndpad assertion failed");

// Antecedent implies consequent in the same cycle
`define NDPAD_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ndpad assertion failed");

// Antecedent implies consequent in the next cycle
`define NDPAD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ndpad assertion failed");

`endif

/* rtl/ndpad_pkg.sv */
// Shared constants and types for the N-dimensional pad address generator.
// No dependencies; used by ndpad_dim_cell and nd_pad_address_generator.
package ndpad_pkg;

    // Geometry sizing
    localparam int MAX_DIMS    = 4;
    localparam int EXTENT_BITS = 12;
    localparam int STRIDE_BITS = 28;
    localparam int ELEM_BITS   = 32;

    // Fixed field widths of the ports and registers
    localparam int COUNT_BITS  = 48;
    localparam int FILL_BITS   = 32;
    localparam int MODE_BITS   = 2;
    localparam int RANK_BITS   = 3;
    localparam int DIM_WORD_W  = 64;
    localparam int CFG_DATA_W  = 64;

    // Register map
    localparam int REG_PAD_MODE   = 0;
    localparam int REG_RANK       = 1;
    localparam int REG_FILL_VALUE = 2;
    localparam int REG_DIM_BASE   = 3;
    localparam int REG_COUNT      = REG_DIM_BASE + MAX_DIMS;
    localparam int CFG_INDEX_W    = $clog2(REG_COUNT);

    // Pad modes; the unused code falls back to constant padding
    localparam logic [MODE_BITS-1:0] MODE_CONSTANT = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_REFLECT  = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_EDGE     = 2'd2;

    // Dimension word layout; bits above the word read as zero
    localparam int GEOM_BITS = 3 * EXTENT_BITS + STRIDE_BITS;
    localparam int GEOM_W    = (GEOM_BITS > DIM_WORD_W) ? GEOM_BITS : DIM_WORD_W;
    localparam int SRC_LSB   = 0;
    localparam int OUT_LSB   = EXTENT_BITS;
    localparam int LEAD_LSB  = 2 * EXTENT_BITS;
    localparam int STR_LSB   = 3 * EXTENT_BITS;

    // Signed working width of a source coordinate, and of its mapped result
    localparam int SRC_W = EXTENT_BITS + 3;
    localparam int MAP_W = EXTENT_BITS + 1;

    // Low ELEM_BITS of the fill register are emitted
    localparam int FILL_KEEP = (ELEM_BITS < FILL_BITS) ? ELEM_BITS : FILL_BITS;
    localparam logic [FILL_BITS-1:0] FILL_MASK = FILL_BITS'((65'd1 << FILL_KEEP) - 65'd1);

    // Per-dimension settings seen by one cell
    typedef struct packed {
        logic [MODE_BITS-1:0]   mode;
        logic                   active;
        logic [EXTENT_BITS-1:0] src_ext;
        logic [EXTENT_BITS-1:0] out_ext;
        logic [EXTENT_BITS-1:0] lead;
        logic [STRIDE_BITS-1:0] stride;
    } dim_cfg_t;

    // Walk and pipeline control broadcast to the cells
    typedef struct packed {
        logic accept;
        logic restart;
        logic wrap;
        logic ld2;
        logic ld3;
    } cell_ctl_t;

endpackage

/* rtl/ndpad_dim_cell.sv */
// One dimension of the pad walk: coordinate counter, carry link and the
// per-dimension offset lane (map, multiply). Depends on ndpad_pkg.
`include "nd_pad_address_generator_macros.svh"

module ndpad_dim_cell
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  ndpad_pkg::cell_ctl_t                ctl,
    input  ndpad_pkg::dim_cfg_t                 cfg,
    input  logic                                carry_in,
    output logic                                carry_out,
    output logic [ndpad_pkg::STRIDE_BITS-1:0]   term,
    output logic                                pad
);

    localparam int E  = ndpad_pkg::EXTENT_BITS;
    localparam int S  = ndpad_pkg::STRIDE_BITS;
    localparam int SW = ndpad_pkg::SRC_W;
    localparam int MW = ndpad_pkg::MAP_W;
    localparam logic signed [SW-1:0] TWO = SW'(2);

    logic [E-1:0]            pos_reg;
    logic [E-1:0]            pos_next;
    logic [E-1:0]            pos_eff;
    logic [E:0]              pos_inc;
    logic [E-1:0]            out_ext_eff;
    logic                    wrap_here;
    logic [E-1:0]            s1_pos_reg;
    logic [MW-1:0]           s2_coord_reg;
    logic                    s2_pad_reg;
    logic [S-1:0]            s3_term_reg;
    logic                    s3_pad_reg;
    logic [MW-1:0]           map_coord;
    logic                    map_pad;
    logic [MW+S-1:0]         prod_full;

    // Coordinate step with carry from the faster neighbor
    always_comb
    begin
        pos_eff     = ctl.restart ? '0 : pos_reg;
        pos_inc     = {1'b0, pos_eff} + (E+1)'(1);
        out_ext_eff = (cfg.out_ext == '0) ? E'(1) : cfg.out_ext;
        wrap_here   = (pos_inc >= {1'b0, out_ext_eff});
        pos_next    = pos_reg;
        carry_out   = carry_in;
        if (ctl.accept)
        begin
            pos_next = pos_eff;
            if (cfg.active)
            begin
                carry_out = carry_in && wrap_here;
                if (carry_in)
                begin
                    pos_next = wrap_here ? '0 : pos_inc[E-1:0];
                end
            end
            if (ctl.wrap)
            begin
                pos_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    // Map output coordinate to source coordinate
    always_comb
    begin
        logic signed [SW-1:0] r;
        logic signed [SW-1:0] xd;
        logic signed [SW-1:0] a;
        logic signed [SW-1:0] m;
        logic signed [SW-1:0] t;
        logic signed [SW-1:0] hi;
        r  = $signed({{(SW-E){1'b0}}, s1_pos_reg})
           - $signed({{(SW-E){cfg.lead[E-1]}}, cfg.lead});
        xd = $signed({{(SW-E){1'b0}}, cfg.src_ext});
        hi = xd - SW'(1);
        a  = (r < 0) ? -r : r;
        m  = xd + xd - a - TWO;
        t  = r;
        map_pad = 1'b0;
        unique case (cfg.mode)
            ndpad_pkg::MODE_REFLECT:
            begin
                t = (m < a) ? m : a;
                if (t < 0) t = '0;
            end
            ndpad_pkg::MODE_EDGE:
            begin
                if (t > hi) t = hi;
                if (t < 0) t = '0;
            end
            default:
            begin
                if ((r < 0) || (r >= xd))
                begin
                    map_pad = 1'b1;
                    t       = '0;
                end
            end
        endcase
        map_coord = t[MW-1:0];
        if (!cfg.active)
        begin
            map_coord = '0;
            map_pad   = 1'b0;
        end
    end

    // Offset term, truncated to the stride width
    assign prod_full = (MW+S)'(s2_coord_reg) * (MW+S)'(cfg.stride);

    // Lane pipeline: snapshot, mapped coordinate, product
    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            s1_pos_reg <= pos_eff;
        end
        if (ctl.ld2)
        begin
            s2_coord_reg <= map_coord;
            s2_pad_reg   <= map_pad;
        end
        if (ctl.ld3)
        begin
            s3_term_reg <= prod_full[S-1:0];
            s3_pad_reg  <= s2_pad_reg;
        end
    end

    assign term = s3_term_reg;
    assign pad  = s3_pad_reg;

endmodule

/* rtl/nd_pad_address_generator.sv */
// An accepted beat passes the snapshot, map and product registers, then the output register.
// Throughput: one beat per cycle unless stalled; the walk's carry chain is combinational.
// Stages behind the walk collapse bubbles, so input is taken while a result waits.
// Reset: walk coordinates and element count go to zero, config to reset values
// (constant mode, rank 1, zero fill and geometry); no clearing pass is needed.
`include "nd_pad_address_generator_macros.svh"

module nd_pad_address_generator
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    // configuration write port
    input  logic                                   cfg_we,
    input  logic [ndpad_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [ndpad_pkg::CFG_DATA_W-1:0]       cfg_data,
    // input channel
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic                                   restart,
    // output channel
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [ndpad_pkg::COUNT_BITS-1:0]       out_index,
    output logic [ndpad_pkg::STRIDE_BITS-1:0]      src_offset,
    output logic                                   use_fill,
    output logic [ndpad_pkg::FILL_BITS-1:0]        fill_bits,
    output logic                                   last
);

    localparam int ND = ndpad_pkg::MAX_DIMS;
    localparam int S  = ndpad_pkg::STRIDE_BITS;
    localparam int CB = ndpad_pkg::COUNT_BITS;
    localparam int E  = ndpad_pkg::EXTENT_BITS;

    // Configuration registers
    logic [ndpad_pkg::MODE_BITS-1:0]  pad_mode_reg;
    logic [ndpad_pkg::RANK_BITS-1:0]  rank_reg;
    logic [ndpad_pkg::FILL_BITS-1:0]  fill_value_reg;
    logic [ndpad_pkg::DIM_WORD_W-1:0] dim_word_reg [ND];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pad_mode_reg   <= ndpad_pkg::MODE_CONSTANT;
            rank_reg       <= ndpad_pkg::RANK_BITS'(1);
            fill_value_reg <= '0;
            for (int d = 0; d < ND; d++)
            begin
                dim_word_reg[d] <= '0;
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index == ndpad_pkg::CFG_INDEX_W'(ndpad_pkg::REG_PAD_MODE))
            begin
                pad_mode_reg <= cfg_data[ndpad_pkg::MODE_BITS-1:0];
            end
            if (cfg_index == ndpad_pkg::CFG_INDEX_W'(ndpad_pkg::REG_RANK))
            begin
                rank_reg <= cfg_data[ndpad_pkg::RANK_BITS-1:0];
            end
            if (cfg_index == ndpad_pkg::CFG_INDEX_W'(ndpad_pkg::REG_FILL_VALUE))
            begin
                fill_value_reg <= cfg_data[ndpad_pkg::FILL_BITS-1:0];
            end
            for (int d = 0; d < ND; d++)
            begin
                if (cfg_index == ndpad_pkg::CFG_INDEX_W'(ndpad_pkg::REG_DIM_BASE + d))
                begin
                    dim_word_reg[d] <= cfg_data[ndpad_pkg::DIM_WORD_W-1:0];
                end
            end
        end
    end

    // Unpack geometry per dimension; rank 0 acts as 1, large rank as all dims
    ndpad_pkg::dim_cfg_t dim_cfg [ND];

    always_comb
    begin
        logic [ndpad_pkg::GEOM_W-1:0] g;
        for (int d = 0; d < ND; d++)
        begin
            g = ndpad_pkg::GEOM_W'(dim_word_reg[d]);
            dim_cfg[d].mode    = pad_mode_reg;
            dim_cfg[d].active  = (d == 0) || (int'(rank_reg) > d);
            dim_cfg[d].src_ext = g[ndpad_pkg::SRC_LSB  +: E];
            dim_cfg[d].out_ext = g[ndpad_pkg::OUT_LSB  +: E];
            dim_cfg[d].lead    = g[ndpad_pkg::LEAD_LSB +: E];
            dim_cfg[d].stride  = g[ndpad_pkg::STR_LSB  +: S];
        end
    end

    // Pipeline occupancy and bubble-collapsing advance
    logic v1_reg, v2_reg, v3_reg, out_valid_reg;
    logic v1_next, v2_next, v3_next, out_valid_next;
    logic ld_out, ld3, ld2, accept;
    logic free3, free2, free1;

    always_comb
    begin
        ld_out   = v3_reg && (!out_valid_reg || !out_stall);
        free3    = !v3_reg || ld_out;
        ld3      = v2_reg && free3;
        free2    = !v2_reg || ld3;
        ld2      = v1_reg && free2;
        free1    = !v1_reg || ld2;
        accept   = in_valid && free1;
        in_stall = !free1;

        out_valid_next = ld_out || (out_valid_reg && out_stall);
        v3_next        = ld3 || (v3_reg && !ld_out);
        v2_next        = ld2 || (v2_reg && !ld3);
        v1_next        = accept || (v1_reg && !ld2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            v3_reg        <= v3_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Row of dimension cells; carry enters at the fastest dimension
    logic                 carry [ND+1];
    logic [S-1:0]         term  [ND];
    logic [ND-1:0]        pad_vec;
    logic                 walk_last;
    ndpad_pkg::cell_ctl_t ctl;

    assign carry[ND]   = 1'b1;
    assign walk_last   = carry[0];
    assign ctl.accept  = accept;
    assign ctl.restart = restart;
    assign ctl.wrap    = walk_last;
    assign ctl.ld2     = ld2;
    assign ctl.ld3     = ld3;

    for (genvar d = 0; d < ND; d++)
    begin : g_cell
        ndpad_dim_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .cfg       (dim_cfg[d]),
            .carry_in  (carry[d+1]),
            .carry_out (carry[d]),
            .term      (term[d]),
            .pad       (pad_vec[d])
        );
    end

    // Element counter
    logic [CB-1:0] cnt_reg;
    logic [CB-1:0] cnt_next;
    logic [CB-1:0] cnt_eff;

    always_comb
    begin
        cnt_eff  = restart ? '0 : cnt_reg;
        cnt_next = cnt_reg;
        if (accept)
        begin
            cnt_next = walk_last ? '0 : cnt_eff + CB'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Index and last marker travel alongside the cell lanes
    logic [CB-1:0] s1_cnt_reg, s2_cnt_reg, s3_cnt_reg;
    logic          s1_last_reg, s2_last_reg, s3_last_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cnt_reg  <= cnt_eff;
            s1_last_reg <= walk_last;
        end
        if (ld2)
        begin
            s2_cnt_reg  <= s1_cnt_reg;
            s2_last_reg <= s1_last_reg;
        end
        if (ld3)
        begin
            s3_cnt_reg  <= s2_cnt_reg;
            s3_last_reg <= s2_last_reg;
        end
    end

    // Sum the lane terms and form the result beat
    logic [S-1:0] offset_sum;
    logic         pad_any;

    always_comb
    begin
        offset_sum = '0;
        for (int d = 0; d < ND; d++)
        begin
            offset_sum = offset_sum + term[d];
        end
        pad_any = |pad_vec;
    end

    logic [CB-1:0]                   out_index_reg;
    logic [S-1:0]                    src_offset_reg;
    logic                            use_fill_reg;
    logic [ndpad_pkg::FILL_BITS-1:0] fill_bits_reg;
    logic                            last_reg;

    always_ff @(posedge clk)
    begin
        if (ld_out)
        begin
            out_index_reg  <= s3_cnt_reg;
            last_reg       <= s3_last_reg;
            use_fill_reg   <= pad_any;
            src_offset_reg <= pad_any ? '0 : offset_sum;
            fill_bits_reg  <= pad_any ? (fill_value_reg & ndpad_pkg::FILL_MASK) : '0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_index  = out_index_reg;
    assign src_offset = src_offset_reg;
    assign use_fill   = use_fill_reg;
    assign fill_bits  = fill_bits_reg;
    assign last       = last_reg;

    // Checks
    `NDPAD_ASSERT_NEXT(a_wrap_clears_count, accept && walk_last, cnt_reg == '0)
    `NDPAD_ASSERT_IMPLY(a_no_fill_bits_on_copy, out_valid && !use_fill, fill_bits == '0)
    `NDPAD_ASSERT_NEXT(a_stage3_holds_when_blocked, v3_reg && out_valid_reg && out_stall, v3_reg)
    `NDPAD_ASSERT_IMPLY(a_empty_front_accepts, !v1_reg, !in_stall)

endmodule

/* tb/sv/tb_nd_pad_address_generator.sv */
// Self-checking testbench for nd_pad_address_generator: directed and random walks
// over constant, reflect and edge padding, with random idling on both channels.
// Depends on ndpad_pkg and the nd_pad_address_generator RTL.
`timescale 1ns / 100ps

module tb_nd_pad_address_generator;

    import ndpad_pkg::*;

    localparam int PIPE_LATENCY = 3;
    localparam int RANDOM_ITEMS = 1050;
    localparam int MAX_WAIT     = 8;
    localparam int REPORT_LIMIT = 10;

    // Mode code with no name in the package; the block treats it as constant
    localparam logic [MODE_BITS-1:0] MODE_UNUSED = 2'd3;

    // One expected output beat
    typedef struct packed {
        logic [COUNT_BITS-1:0]  elem_idx;
        logic [STRIDE_BITS-1:0] ofs;
        logic                   fill;
        logic [FILL_BITS-1:0]   fbits;
        logic                   last;
    } pad_result_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    logic                   restart;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [COUNT_BITS-1:0]  out_index;
    logic [STRIDE_BITS-1:0] src_offset;
    logic                   use_fill;
    logic [FILL_BITS-1:0]   fill_bits;
    logic                   last;

    // Register mirror, at reset values
    logic [MODE_BITS-1:0]  cfg_mode = MODE_CONSTANT;
    logic [RANK_BITS-1:0]  cfg_rank = 3'd1;
    logic [FILL_BITS-1:0]  cfg_fill = '0;
    logic [DIM_WORD_W-1:0] cfg_dim [MAX_DIMS] = '{default: '0};

    // Walk state
    logic [EXTENT_BITS-1:0] walk_pos [MAX_DIMS] = '{default: '0};
    logic [COUNT_BITS-1:0]  elem_count = '0;

    pad_result_t expected_q [$];
    bit          no_idle = 1'b0;
    int          fail_count = 0;
    int          beats_sent = 0;
    int          results_seen = 0;
    int          wait_left = 0;

    nd_pad_address_generator u_top
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .restart    (restart),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_index  (out_index),
        .src_offset (src_offset),
        .use_fill   (use_fill),
        .fill_bits  (fill_bits),
        .last       (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Idle cycles before a beat, on either side
    function automatic int pick_wait();
        return no_idle ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    // Map the current walk position to its source element, then advance the walk
    function automatic pad_result_t step_walk(input logic rs);
        pad_result_t res;
        int n;
        int d;
        logic hit;
        logic carry;
        longint ofs_sum;
        longint xd;
        longint r;
        longint m;
        longint oe;
        logic signed [EXTENT_BITS-1:0] lead;
        if (rs)
        begin
            for (d = 0; d < MAX_DIMS; d++)
                walk_pos[d] = '0;
            elem_count = '0;
        end
        // rank 0 acts as 1, ranks above the dimension count saturate
        if (cfg_rank == 0)
            n = 1;
        else if (cfg_rank > MAX_DIMS)
            n = MAX_DIMS;
        else
            n = int'(cfg_rank);
        hit = 1'b0;
        ofs_sum = 0;
        for (d = 0; d < n; d++)
        begin
            xd = longint'(cfg_dim[d][SRC_LSB +: EXTENT_BITS]);
            lead = cfg_dim[d][LEAD_LSB +: EXTENT_BITS];
            r = longint'(walk_pos[d]) - longint'(lead);
            case (cfg_mode)
                MODE_REFLECT:
                begin
                    // mirror without repeating the edge; tiny sources pin to 0
                    if (r < 0)
                        r = -r;
                    m = 2 * xd - r - 2;
                    if (m < r)
                        r = m;
                    if (r < 0)
                        r = 0;
                end
                MODE_EDGE:
                begin
                    if (r < 0)
                        r = 0;
                    if (r > xd - 1)
                        r = xd - 1;
                    if (r < 0)
                        r = 0;
                end
                default:
                begin
                    if (r < 0 || r >= xd)
                    begin
                        hit = 1'b1;
                        r = 0;
                    end
                end
            endcase
            ofs_sum += r * longint'(cfg_dim[d][STR_LSB +: STRIDE_BITS]);
        end
        res.elem_idx = elem_count;
        res.ofs = hit ? '0 : ofs_sum[STRIDE_BITS-1:0];
        res.fill = hit;
        res.fbits = hit ? (cfg_fill & FILL_MASK) : '0;

        // Row-major advance, last dimension fastest; zero extent acts as 1
        carry = 1'b1;
        for (d = n - 1; d >= 0; d--)
        begin
            if (carry)
            begin
                oe = longint'(cfg_dim[d][OUT_LSB +: EXTENT_BITS]);
                if (oe == 0)
                    oe = 1;
                if (longint'(walk_pos[d]) + 1 >= oe)
                    walk_pos[d] = '0;
                else
                begin
                    walk_pos[d] = walk_pos[d] + 1'b1;
                    carry = 1'b0;
                end
            end
        end
        res.last = carry;
        if (carry)
        begin
            for (d = 0; d < MAX_DIMS; d++)
                walk_pos[d] = '0;
            elem_count = '0;
        end
        else
            elem_count = elem_count + 1'b1;
        return res;
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("[%0t] ERROR: %s", $realtime, msg);
    endtask

    // Register write; the strobe drops with the next beat sent
    task automatic write_cfg(input int idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx[CFG_INDEX_W-1:0];
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            REG_PAD_MODE:   cfg_mode = data[MODE_BITS-1:0];
            REG_RANK:       cfg_rank = data[RANK_BITS-1:0];
            REG_FILL_VALUE: cfg_fill = data[FILL_BITS-1:0];
            default:
            begin
                if (idx >= REG_DIM_BASE && idx < REG_COUNT)
                    cfg_dim[idx - REG_DIM_BASE] = data;
            end
        endcase
    endtask

    task automatic program_dim(input int d, input int src, input int oext, input int lead,
                               input int stride);
        logic [DIM_WORD_W-1:0] w;
        w = '0;
        w[SRC_LSB +: EXTENT_BITS]  = src[EXTENT_BITS-1:0];
        w[OUT_LSB +: EXTENT_BITS]  = oext[EXTENT_BITS-1:0];
        w[LEAD_LSB +: EXTENT_BITS] = lead[EXTENT_BITS-1:0];
        w[STR_LSB +: STRIDE_BITS]  = stride[STRIDE_BITS-1:0];
        write_cfg(REG_DIM_BASE + d, w);
    endtask

    // Send one beat and record what it should produce
    task automatic send_beat(input logic rs);
        int gap;
        gap = pick_wait();
        cfg_we <= 1'b0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        restart  <= rs;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_q.push_back(step_walk(rs));
        beats_sent++;
    endtask

    // Stop sending and let every pending result come out
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY) @(posedge clk);
    endtask

    // Mostly small geometry so walks wrap; sometimes fully random words
    function automatic logic [DIM_WORD_W-1:0] random_geometry();
        logic [DIM_WORD_W-1:0] w;
        int lead;
        w = {$urandom, $urandom};
        if ($urandom_range(0, 7) != 0)
        begin
            lead = int'($urandom_range(0, 6)) - 3;
            w[SRC_LSB +: EXTENT_BITS]  = EXTENT_BITS'($urandom_range(0, 6));
            w[OUT_LSB +: EXTENT_BITS]  = EXTENT_BITS'($urandom_range(0, 5));
            w[LEAD_LSB +: EXTENT_BITS] = lead[EXTENT_BITS-1:0];
        end
        case ($urandom_range(0, 7))
            0: w[STR_LSB +: STRIDE_BITS] = '0;
            1: w[STR_LSB +: STRIDE_BITS] = '1;
            default: ;
        endcase
        return w;
    endfunction

    // Output side: random stall after each accepted beat
    always @(posedge clk)
    begin
        if (!rst_n)
            wait_left = 0;
        else if (out_valid && !out_stall)
            wait_left = pick_wait();
        else if (wait_left != 0)
            wait_left = wait_left - 1;
        out_stall <= (wait_left != 0);
    end

    // Compare every accepted result with the oldest pending one
    always @(posedge clk)
    begin : result_check
        pad_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (expected_q.size() == 0)
                note_failure($sformatf("result idx=%0d with nothing pending", out_index));
            else
            begin
                want = expected_q.pop_front();
                if (out_index !== want.elem_idx || src_offset !== want.ofs ||
                    use_fill !== want.fill || fill_bits !== want.fbits || last !== want.last)
                    note_failure({
                        $sformatf("exp idx=%0d ofs=%h fill=%b bits=%h last=%b, ",
                                  want.elem_idx, want.ofs, want.fill, want.fbits,
                                  want.last),
                        $sformatf("got idx=%0d ofs=%h fill=%b bits=%h last=%b",
                                  out_index, src_offset, use_fill, fill_bits, last)});
            end
        end
    end

    // Reset values: one element, empty source, constant mode, so every beat pads with 0
    task automatic test_reset_state();
        drain();
        repeat (2) send_beat(1'b0);
    endtask

    // 2x2 output: leading pad on dim 0, crop on dim 1, max stride and all-ones fill
    task automatic test_constant_pad();
        drain();
        write_cfg(REG_PAD_MODE, CFG_DATA_W'(MODE_CONSTANT));
        write_cfg(REG_RANK, CFG_DATA_W'(2));
        write_cfg(REG_FILL_VALUE, 64'hFFFF_FFFF);
        program_dim(0, 1, 2, 1, 100);
        program_dim(1, 3, 2, -1, 32'h0FFF_FFFF);
        repeat (4) send_beat(1'b0);
    endtask

    // Coordinates -2..1 mirror to 2,1,0,1
    task automatic test_reflect_pad();
        drain();
        write_cfg(REG_PAD_MODE, CFG_DATA_W'(MODE_REFLECT));
        write_cfg(REG_RANK, CFG_DATA_W'(1));
        program_dim(0, 3, 4, 2, 5);
        repeat (4) send_beat(1'b0);
    endtask

    // Coordinates -1..2 clamp to 0,0,1,1
    task automatic test_edge_pad();
        drain();
        write_cfg(REG_PAD_MODE, CFG_DATA_W'(MODE_EDGE));
        program_dim(0, 2, 4, 1, 7);
        repeat (4) send_beat(1'b0);
    endtask

    task automatic test_special_cases();
        drain();
        // unknown register index, unused mode, rank 0, zero out extent, extreme lead
        write_cfg(REG_COUNT, '1);
        write_cfg(REG_PAD_MODE, CFG_DATA_W'(MODE_UNUSED));
        write_cfg(REG_RANK, CFG_DATA_W'(0));
        program_dim(0, 4095, 0, -2048, 32'h0FFF_FFFF);
        send_beat(1'b0);

        // rank above range; source extents 1 and 0 reflect below zero
        drain();
        write_cfg(REG_PAD_MODE, CFG_DATA_W'(MODE_REFLECT));
        write_cfg(REG_RANK, CFG_DATA_W'(7));
        program_dim(0, 1, 2, 0, 3);
        program_dim(1, 0, 1, 0, 11);
        program_dim(2, 4095, 1, 2047, 13);
        program_dim(3, 2, 2, 0, 1);
        repeat (4) send_beat(1'b0);

        // edge clamp with empty source, then restart mid-walk
        drain();
        write_cfg(REG_PAD_MODE, CFG_DATA_W'(MODE_EDGE));
        send_beat(1'b0);
        send_beat(1'b0);
        send_beat(1'b1);

        // shrink the extent below the current coordinate: it wraps with carry
        drain();
        write_cfg(REG_PAD_MODE, CFG_DATA_W'(MODE_CONSTANT));
        write_cfg(REG_RANK, CFG_DATA_W'(1));
        program_dim(0, 8, 4, 0, 2);
        repeat (3) send_beat(1'b0);
        drain();
        program_dim(0, 8, 2, 0, 2);
        send_beat(1'b0);
    endtask

    // Random settings between bursts; the walk carries across them
    task automatic test_random_walks();
        int sent;
        int burst;
        int d;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            drain();
            no_idle = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 1) == 0)
                write_cfg(REG_PAD_MODE, CFG_DATA_W'($urandom_range(0, 3)));
            if ($urandom_range(0, 1) == 0)
                write_cfg(REG_RANK, CFG_DATA_W'($urandom_range(0, 7)));
            if ($urandom_range(0, 3) == 0)
                write_cfg(REG_FILL_VALUE, {32'd0, $urandom});
            for (d = 0; d < MAX_DIMS; d++)
            begin
                if ($urandom_range(0, 1) == 0)
                    write_cfg(REG_DIM_BASE + d, random_geometry());
            end
            if ($urandom_range(0, 7) == 0)
                write_cfg(REG_COUNT, {$urandom, $urandom});
            burst = $urandom_range(8, 60);
            repeat (burst)
            begin
                send_beat($urandom_range(0, 31) == 0);
                sent++;
            end
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        restart   <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_constant_pad();
        test_reflect_pad();
        test_edge_pad();
        test_special_cases();
        test_random_walks();

        drain();
        repeat (4 * PIPE_LATENCY) @(posedge clk);
        if (expected_q.size() != 0)
            note_failure($sformatf("%0d results never arrived", expected_q.size()));

        $display("Sent %0d beats over constant, reflect and edge modes; %0d results checked.",
                 beats_sent, results_seen);
        $display("Failures: %0d", fail_count);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(5_000_000);
        $display("Timeout with %0d results pending", expected_q.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule

/* nd_pad_address_generator.f */
+incdir+rtl
rtl/ndpad_pkg.sv
rtl/ndpad_dim_cell.sv
rtl/nd_pad_address_generator.sv
tb/sv/tb_nd_pad_address_generator.sv
